### src/bovg_pkg.sv
// Shared types, constants and helpers for the box outline vertex generator.
// Used by box_outline_vertex_generator; no other dependencies.
package bovg_pkg;

  localparam int COORD_FRAC_BITS = 16;

  localparam int ONE_Q  = 1 << COORD_FRAC_BITS;
  // |delta| below 32 blocks fits this many magnitude bits
  localparam int MAG_W  = COORD_FRAC_BITS + 5;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 2;

  localparam logic [31:0] OFF_FAR  = 32'((ONE_Q + 50) / 100);
  localparam logic [31:0] OFF_MID  = 32'((ONE_Q + 80) / 160);
  localparam logic [31:0] OFF_NEAR = 32'((ONE_Q + 100) / 200);
  localparam logic [31:0] W_16     = 32'((ONE_Q + 8) / 16);
  localparam logic [31:0] W_32     = 32'((ONE_Q + 16) / 32);
  localparam logic [31:0] W_64     = 32'((ONE_Q + 32) / 64);
  localparam logic [31:0] W_96     = 32'((ONE_Q + 48) / 96);
  localparam logic [31:0] W_128    = 32'((ONE_Q + 64) / 128);
  localparam logic [31:0] W_192    = 32'((ONE_Q + 96) / 192);

  localparam logic [32:0] FAR_LIM = 33'(64'd32 << COORD_FRAC_BITS);

  // squared-distance thresholds: 2^2, 4^2, 8^2, 16^2, 32^2 blocks
  localparam logic [DIST_W-1:0] DIST_2  = DIST_W'(64'd4 << (2 * COORD_FRAC_BITS));
  localparam logic [DIST_W-1:0] DIST_4  = DIST_W'(64'd16 << (2 * COORD_FRAC_BITS));
  localparam logic [DIST_W-1:0] DIST_8  = DIST_W'(64'd64 << (2 * COORD_FRAC_BITS));
  localparam logic [DIST_W-1:0] DIST_16 = DIST_W'(64'd256 << (2 * COORD_FRAC_BITS));
  localparam logic [DIST_W-1:0] DIST_32 = DIST_W'(64'd1024 << (2 * COORD_FRAC_BITS));

  localparam int NUM_PAIRS = 48;
  localparam int CNT_W     = 6;
  localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(NUM_PAIRS - 1);

  localparam logic [31:0] COLOR_RESET = 32'h6600_0000;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic        [31:0] vertex_color;
    logic               last_pair;
  } out_item_t;

  // index 0 = x, 1 = y, 2 = z
  typedef logic [2:0][31:0] vec3_t;

  // grown corners and the corners pulled in by the border width
  typedef struct packed {
    vec3_t a;
    vec3_t b;
    vec3_t aw;
    vec3_t bw;
  } corners_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_AW,
    SEL_BW
  } sel_t;

  typedef struct packed {
    sel_t ua;
    sel_t va;
    sel_t ub;
    sel_t vb;
  } quad_sel_t;

  // Same four border strips on every face, in plane coordinates (u, v)
  function automatic quad_sel_t quad_codes(input logic [1:0] sub);
    quad_sel_t q;
    case (sub)
      2'd0:    q = '{ua: SEL_A, va: SEL_AW, ub: SEL_AW, vb: SEL_BW};
      2'd1:    q = '{ua: SEL_B, va: SEL_AW, ub: SEL_BW, vb: SEL_BW};
      2'd2:    q = '{ua: SEL_A, va: SEL_A,  ub: SEL_B,  vb: SEL_AW};
      default: q = '{ua: SEL_A, va: SEL_B,  ub: SEL_B,  vb: SEL_BW};
    endcase
    return q;
  endfunction

  // signed 32-bit add with saturation
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] pick(input corners_t c, input logic [1:0] axis,
                                       input sel_t s);
    logic [31:0] v;
    case (s)
      SEL_A:   v = c.a[axis];
      SEL_B:   v = c.b[axis];
      SEL_AW:  v = c.aw[axis];
      default: v = c.bw[axis];
    endcase
    return v;
  endfunction

endpackage

### src/box_outline_vertex_generator.sv
// Box outline vertex generator top level: setup pipeline and pair emitter.
// Depends on bovg_pkg.
//
// Use: drive in_item and raise start; the item is taken at an edge where
// start is high and busy is low. Each box gives 48 results, two vertices
// each, on out_item with out_valid high for one cycle per result; the 48th
// carries last_pair. The receiver has no way to stall, so results come one
// per cycle, back to back.
// The first result of a box passes the 7 setup stages, the emitter load
// and the output register; the emitter loads a box when idle or at the
// last pair of the one before, and its pair counter paces the 48 results.
// The setup pipeline (delta, magnitude, squares, sum, selection, grow,
// width) works on the next boxes meanwhile and busy rises when it is full.
// cfg_data is written to the colour register when cfg_valid is high
// (cfg_ready is always high); write only while no box is in flight.
// Reset (rst_n low at an edge) empties the pipeline, stops the emitter and
// sets the colour to 0x66000000.
module box_outline_vertex_generator
  import bovg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] color_r;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic accept;
  logic load_emit;

  // stage payloads
  vec3_t             mn1_r, mx1_r;
  logic [2:0][32:0]  d1_r;
  vec3_t             mn2_r, mx2_r;
  logic [2:0][MAG_W-1:0] a2_r;
  logic              far2_r;
  vec3_t             mn3_r, mx3_r;
  logic [2:0][SQ_W-1:0] sq3_r;
  logic              far3_r;
  vec3_t             mn4_r, mx4_r;
  logic [DIST_W-1:0] dist4_r;
  logic              far4_r;
  vec3_t             mn5_r, mx5_r;
  logic [31:0]       off5_r, w5_r;
  vec3_t             a6_r, b6_r;
  logic [31:0]       w6_r;
  corners_t          c7_r;

  // emitter
  corners_t          cur_r;
  logic              act_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;

  logic [2:0][32:0]      d_nxt;
  logic [2:0][MAG_W-1:0] a_nxt;
  logic                  far_nxt;
  logic [2:0][SQ_W-1:0]  sq_nxt;
  logic [DIST_W-1:0]     dist_nxt;
  logic [31:0]           off_nxt, w_nxt;

  assign cfg_ready = 1'b1;

  // stall chain from the emitter back to the input
  assign load_emit = v7_r && (!act_r || cnt_r == LAST_PAIR);
  assign rdy7 = !v7_r || load_emit;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign busy   = !rdy1;
  assign accept = start && rdy1;

  always_comb begin
    d_nxt[0] = {in_item.camera_x[31], in_item.camera_x}
             - {in_item.box_min_x[31], in_item.box_min_x};
    d_nxt[1] = {in_item.camera_y[31], in_item.camera_y}
             - {in_item.box_min_y[31], in_item.box_min_y};
    d_nxt[2] = {in_item.camera_z[31], in_item.camera_z}
             - {in_item.box_min_z[31], in_item.box_min_z};
  end

  always_comb begin
    logic [32:0] mag;
    far_nxt = 1'b0;
    a_nxt   = '0;
    for (int i = 0; i < 3; i++) begin
      mag = d1_r[i][32] ? (~d1_r[i] + 33'd1) : d1_r[i];
      if (mag >= FAR_LIM) far_nxt = 1'b1;
      a_nxt[i] = mag[MAG_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQ_W'(a2_r[i]) * SQ_W'(a2_r[i]);
    end
  end

  assign dist_nxt = DIST_W'(sq3_r[0]) + DIST_W'(sq3_r[1]) + DIST_W'(sq3_r[2]);

  always_comb begin
    off_nxt = OFF_FAR;
    w_nxt   = W_16;
    if (!far4_r) begin
      if (dist4_r < DIST_2)       off_nxt = OFF_NEAR;
      else if (dist4_r < DIST_4)  off_nxt = OFF_MID;
      if (dist4_r < DIST_2)       w_nxt = W_192;
      else if (dist4_r < DIST_4)  w_nxt = W_128;
      else if (dist4_r < DIST_8)  w_nxt = W_96;
      else if (dist4_r < DIST_16) w_nxt = W_64;
      else if (dist4_r < DIST_32) w_nxt = W_32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mn1_r <= {in_item.box_min_z, in_item.box_min_y, in_item.box_min_x};
      mx1_r <= {in_item.box_max_z, in_item.box_max_y, in_item.box_max_x};
      d1_r  <= d_nxt;
    end
    if (rdy2) begin
      mn2_r  <= mn1_r;
      mx2_r  <= mx1_r;
      a2_r   <= a_nxt;
      far2_r <= far_nxt;
    end
    if (rdy3) begin
      mn3_r  <= mn2_r;
      mx3_r  <= mx2_r;
      sq3_r  <= sq_nxt;
      far3_r <= far2_r;
    end
    if (rdy4) begin
      mn4_r   <= mn3_r;
      mx4_r   <= mx3_r;
      dist4_r <= dist_nxt;
      far4_r  <= far3_r;
    end
    if (rdy5) begin
      mn5_r  <= mn4_r;
      mx5_r  <= mx4_r;
      off5_r <= off_nxt;
      w5_r   <= w_nxt;
    end
    if (rdy6) begin
      for (int i = 0; i < 3; i++) begin
        a6_r[i] <= sat_add(mn5_r[i], ~off5_r + 32'd1);
        b6_r[i] <= sat_add(mx5_r[i], off5_r);
      end
      w6_r <= w5_r;
    end
    if (rdy7) begin
      for (int i = 0; i < 3; i++) begin
        c7_r.a[i]  <= a6_r[i];
        c7_r.b[i]  <= b6_r[i];
        c7_r.aw[i] <= sat_add(a6_r[i], w6_r);
        c7_r.bw[i] <= sat_add(b6_r[i], ~w6_r + 32'd1);
      end
    end
  end

  // Pair k: face group k[5:4] (bottom/top, left/right, front/back),
  // strip k[3:1] (bit 3 picks the far face), k[0] picks corners 2,3 over 0,1.
  always_comb begin
    quad_sel_t   q;
    logic        odd;
    sel_t        p, fu, fv, su, sv;
    sel_t        fx, fy, fz, sx, sy, sz;
    q   = quad_codes(cnt_r[2:1]);
    odd = cnt_r[0];
    p   = cnt_r[3] ? SEL_B : SEL_A;
    fu  = odd ? q.ub : q.ua;
    fv  = odd ? q.vb : q.va;
    su  = odd ? q.ub : q.ua;
    sv  = odd ? q.va : q.vb;
    case (cnt_r[5:4])
      2'd0: begin
        fx = fu; fy = p;  fz = fv;
        sx = su; sy = p;  sz = sv;
      end
      2'd1: begin
        fx = p;  fy = fv; fz = fu;
        sx = p;  sy = sv; sz = su;
      end
      default: begin
        fx = fu; fy = fv; fz = p;
        sx = su; sy = sv; sz = p;
      end
    endcase
    out_item_nxt.first_x      = pick(cur_r, 2'd0, fx);
    out_item_nxt.first_y      = pick(cur_r, 2'd1, fy);
    out_item_nxt.first_z      = pick(cur_r, 2'd2, fz);
    out_item_nxt.second_x     = pick(cur_r, 2'd0, sx);
    out_item_nxt.second_y     = pick(cur_r, 2'd1, sy);
    out_item_nxt.second_z     = pick(cur_r, 2'd2, sz);
    out_item_nxt.vertex_color = color_r;
    out_item_nxt.last_pair    = act_r && (cnt_r == LAST_PAIR);
  end

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(1);
    if (load_emit) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      color_r     <= COLOR_RESET;
    end else begin
      if (cfg_valid) color_r <= cfg_data;
      out_valid_r <= act_r;
      if (load_emit) begin
        act_r <= 1'b1;
        cnt_r <= cnt_nxt;
      end else if (act_r) begin
        cnt_r <= cnt_nxt;
        if (cnt_r == LAST_PAIR) act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit) cur_r <= c7_r;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    load_emit |-> (!act_r || cnt_r == LAST_PAIR))
    else $error("emitter reloaded mid-box");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (cnt_r <= LAST_PAIR))
    else $error("pair counter out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> v1_r)
    else $error("accepted item did not enter the pipeline");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && cnt_r == LAST_PAIR && !v7_r) |=> !act_r)
    else $error("emitter kept running after the last pair");

endmodule
